/* design/multichannel_trimmed_mean_defines.svh */
// ----------------------------------------------------------------------------
// multichannel_trimmed_mean_defines.svh
// Assertion macros used by the checker file of the trimmed mean block.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_TRIMMED_MEAN_DEFINES_SVH
`define MULTICHANNEL_TRIMMED_MEAN_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define MTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtm checker: next-cycle property failed");

// Consequent must hold in the cycle of the antecedent, outside reset.
`define MTM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtm checker: same-cycle property failed");

// Property that also covers the reset cycles themselves.
`define MTM_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mtm checker: reset property failed");

`endif

/* design/mtm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_pkg
// Sizes, derived widths and shared types of the multichannel trimmed mean.
// ----------------------------------------------------------------------------
package mtm_pkg;

  // Block sizes
  localparam int SAMPLES    = 5;
  localparam int TRIM       = 1;
  localparam int CHANNELS   = 7;
  localparam int NUM_FIELDS = 7;
  localparam int DATA_W     = 8;

  // Derived sizes
  localparam int ACT_CH    = (CHANNELS < NUM_FIELDS) ? CHANNELS : NUM_FIELDS;
  localparam int DEPTH     = ACT_CH * SAMPLES;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CH_W      = (ACT_CH > 1) ? $clog2(ACT_CH) : 1;
  localparam int IDX_W     = $clog2(SAMPLES);
  localparam int SUM_W     = $clog2(((1 << DATA_W) - 1) * SAMPLES + 1);
  localparam bit KEEP_ANY  = (SAMPLES > 2 * TRIM);
  localparam int KEPT      = KEEP_ANY ? (SAMPLES - 2 * TRIM) : 1;

  // Reciprocal of the kept count, exact for every sum below 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + $clog2(KEPT);
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + KEPT - 1) / KEPT;
  localparam int PROD_W    = SUM_W + DIV_SHIFT + 1;

  typedef logic [DATA_W-1:0] sample_t;

  // Sequencer to rank unit controls
  typedef struct packed {
    logic             load_i;   // read issued for the pivot sample
    logic             cmp_j;    // read issued for a compared sample
    logic [IDX_W-1:0] j;        // index of the compared sample
    logic [IDX_W-1:0] i;        // index of the pivot sample
    logic             sum_clr;  // start of a channel
    logic             sum_add;  // pivot rank is final
  } rank_ctl_t;

endpackage

/* design/mtm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mtm_rank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_rank
// Shared compare unit: ranks one pivot sample against its channel and adds
// the pivot to the channel sum when its rank falls inside the kept window.
// ----------------------------------------------------------------------------
module mtm_rank (
  input  logic                      clk,
  input  logic                      rst,
  input  mtm_pkg::rank_ctl_t        ctl,
  input  mtm_pkg::sample_t          rd_data,
  output logic [mtm_pkg::SUM_W-1:0] sum
);

  logic                      load_q;
  logic                      cmp_q;
  logic [mtm_pkg::IDX_W-1:0] j_q;
  mtm_pkg::sample_t          pivot;
  logic [mtm_pkg::IDX_W-1:0] rank;
  logic                      below;
  logic                      keep;

  // Align read tags with the registered RAM data
  always_ff @(posedge clk) begin
    if (rst) begin
      load_q <= 1'b0;
      cmp_q  <= 1'b0;
    end else begin
      load_q <= ctl.load_i;
      cmp_q  <= ctl.cmp_j;
    end
  end

  always_ff @(posedge clk) begin
    j_q <= ctl.j;
  end

  // Ties go to the lower index, so equal samples still get distinct ranks
  assign below = (rd_data < pivot) || ((rd_data == pivot) && (j_q < ctl.i));

  // Latch pivot, count samples ranked below it
  always_ff @(posedge clk) begin
    if (load_q) begin
      pivot <= rd_data;
      rank  <= '0;
    end else if (cmp_q && below) begin
      rank <= rank + 1'b1;
    end
  end

  assign keep = (int'(rank) >= mtm_pkg::TRIM) &&
                (int'(rank) < (mtm_pkg::SAMPLES - mtm_pkg::TRIM));

  // Accumulate kept samples
  always_ff @(posedge clk) begin
    if (ctl.sum_clr) begin
      sum <= '0;
    end else if (ctl.sum_add && keep) begin
      sum <= sum + mtm_pkg::SUM_W'(pivot);
    end
  end

endmodule

/* design/mtm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_div
// Divides the channel sum by the kept count with a reciprocal multiply.
// The quotient is registered and valid in the cycle after start.
// ----------------------------------------------------------------------------
module mtm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mtm_pkg::SUM_W-1:0] dividend,
  output logic                      done,
  output mtm_pkg::sample_t          quot
);

  logic [mtm_pkg::PROD_W-1:0] prod;

  // Multiply by the scaled reciprocal of the kept count
  assign prod = mtm_pkg::PROD_W'(dividend) * mtm_pkg::PROD_W'(mtm_pkg::DIV_MULT);

  // Done strobe in the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // Hold the quotient; nothing kept gives a zero mean
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= mtm_pkg::KEEP_ANY ? prod[mtm_pkg::DIV_SHIFT +: mtm_pkg::DATA_W] : '0;
    end
  end

endmodule

/* design/multichannel_trimmed_mean.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_trimmed_mean
// Collects conversion rounds of per-channel samples and, after the last
// round, returns the trimmed mean of every channel in one output word.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+----------------------------
//  in      | in_valid/in_ready  | sample_ch0 .. sample_ch6
//  out     | out_valid/out_ready| mean_ch0 .. mean_ch6
//
//  In a round, the word is taken in S_IDLE and the samples then go into the
//  sample RAM through its single write port, one channel per cycle.
//  After the last round, one shared comparator ranks every sample against
//  its channel, pivot by pivot, and one reciprocal multiply forms each mean.
//  Synchronous reset clears control state; no clearing pass over the RAM.
//  A result waiting on out_ready does not block new rounds; only the load of
//  the next result waits for the output register to empty.
// ----------------------------------------------------------------------------
module multichannel_trimmed_mean (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] sample_ch0,
  input  logic [7:0] sample_ch1,
  input  logic [7:0] sample_ch2,
  input  logic [7:0] sample_ch3,
  input  logic [7:0] sample_ch4,
  input  logic [7:0] sample_ch5,
  input  logic [7:0] sample_ch6,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] mean_ch0,
  output logic [7:0] mean_ch1,
  output logic [7:0] mean_ch2,
  output logic [7:0] mean_ch3,
  output logic [7:0] mean_ch4,
  output logic [7:0] mean_ch5,
  output logic [7:0] mean_ch6
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_WRITE    = 9'b000000010,
    S_ISSUE_I  = 9'b000000100,
    S_SCAN     = 9'b000001000,
    S_DRAIN    = 9'b000010000,
    S_ADD      = 9'b000100000,
    S_DIV      = 9'b001000000,
    S_WAIT_DIV = 9'b010000000,
    S_LOAD_OUT = 9'b100000000
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [mtm_pkg::IDX_W-1:0]  round;
  logic [mtm_pkg::CH_W-1:0]   ch;
  logic [mtm_pkg::ADDR_W-1:0] base;
  logic [mtm_pkg::IDX_W-1:0]  i;
  logic [mtm_pkg::IDX_W-1:0]  j;
  mtm_pkg::sample_t           in_samp   [mtm_pkg::NUM_FIELDS];
  mtm_pkg::sample_t           word      [mtm_pkg::ACT_CH];
  mtm_pkg::sample_t           mean_work [mtm_pkg::ACT_CH];
  mtm_pkg::sample_t           out_mean  [mtm_pkg::NUM_FIELDS];

  logic                       last_ch;
  logic                       last_round;
  logic                       last_i;
  logic                       last_j;
  logic                       out_free;
  logic                       ram_we;
  logic [mtm_pkg::ADDR_W-1:0] ram_waddr;
  logic [mtm_pkg::ADDR_W-1:0] ram_raddr;
  mtm_pkg::sample_t           ram_rdata;
  mtm_pkg::rank_ctl_t         rank_ctl;
  logic [mtm_pkg::SUM_W-1:0]  sum;
  logic                       div_done;
  mtm_pkg::sample_t           div_quot;

  assign in_samp[0] = sample_ch0;
  assign in_samp[1] = sample_ch1;
  assign in_samp[2] = sample_ch2;
  assign in_samp[3] = sample_ch3;
  assign in_samp[4] = sample_ch4;
  assign in_samp[5] = sample_ch5;
  assign in_samp[6] = sample_ch6;

  assign last_ch    = (ch == mtm_pkg::CH_W'(mtm_pkg::ACT_CH - 1));
  assign last_round = (round == mtm_pkg::IDX_W'(mtm_pkg::SAMPLES - 1));
  assign last_i     = (i == mtm_pkg::IDX_W'(mtm_pkg::SAMPLES - 1));
  assign last_j     = (j == mtm_pkg::IDX_W'(mtm_pkg::SAMPLES - 1));
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_WRITE;
      S_WRITE:    if (last_ch) state_next = last_round ? S_ISSUE_I : S_IDLE;
      S_ISSUE_I:  state_next = S_SCAN;
      S_SCAN:     if (last_j) state_next = S_DRAIN;
      S_DRAIN:    state_next = S_ADD;
      S_ADD:      state_next = last_i ? S_DIV : S_ISSUE_I;
      S_DIV:      state_next = S_WAIT_DIV;
      S_WAIT_DIV: if (div_done) state_next = last_ch ? S_LOAD_OUT : S_ISSUE_I;
      S_LOAD_OUT: if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance round, channel and sample counters
  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
      ch    <= '0;
      base  <= '0;
      i     <= '0;
      j     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          ch   <= '0;
          base <= '0;
        end
        S_WRITE: begin
          if (last_ch) begin
            ch   <= '0;
            base <= '0;
            i    <= '0;
            round <= last_round ? '0 : round + 1'b1;
          end else begin
            ch   <= ch + 1'b1;
            base <= base + mtm_pkg::ADDR_W'(mtm_pkg::SAMPLES);
          end
        end
        S_ISSUE_I: j <= '0;
        S_SCAN:    if (!last_j) j <= j + 1'b1;
        S_ADD:     if (!last_i) i <= i + 1'b1;
        S_WAIT_DIV: begin
          if (div_done && !last_ch) begin
            ch   <= ch + 1'b1;
            base <= base + mtm_pkg::ADDR_W'(mtm_pkg::SAMPLES);
            i    <= '0;
          end
        end
        S_DRAIN, S_DIV, S_LOAD_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted word and the per-channel means
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int k = 0; k < mtm_pkg::ACT_CH; k++) begin
        word[k] <= in_samp[k];
      end
    end
    if (state == S_WAIT_DIV && div_done) begin
      mean_work[ch] <= div_quot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_LOAD_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the means; fields above the active channels read zero
  always_ff @(posedge clk) begin
    if (state == S_LOAD_OUT && out_free) begin
      for (int k = 0; k < mtm_pkg::NUM_FIELDS; k++) begin
        if (k < mtm_pkg::ACT_CH) begin
          out_mean[k] <= mean_work[k];
        end else begin
          out_mean[k] <= '0;
        end
      end
    end
  end

  assign mean_ch0 = out_mean[0];
  assign mean_ch1 = out_mean[1];
  assign mean_ch2 = out_mean[2];
  assign mean_ch3 = out_mean[3];
  assign mean_ch4 = out_mean[4];
  assign mean_ch5 = out_mean[5];
  assign mean_ch6 = out_mean[6];

  // Sample store access
  assign ram_we    = (state == S_WRITE);
  assign ram_waddr = base + mtm_pkg::ADDR_W'(round);
  assign ram_raddr = base + mtm_pkg::ADDR_W'((state == S_SCAN) ? j : i);

  mtm_ram #(
    .WIDTH (mtm_pkg::DATA_W),
    .DEPTH (mtm_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (word[ch]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Rank unit controls
  always_comb begin
    rank_ctl.load_i  = (state == S_ISSUE_I);
    rank_ctl.cmp_j   = (state == S_SCAN);
    rank_ctl.j       = j;
    rank_ctl.i       = i;
    rank_ctl.sum_clr = (state == S_ISSUE_I) && (i == '0);
    rank_ctl.sum_add = (state == S_ADD);
  end

  mtm_rank u_rank (
    .clk     (clk),
    .rst     (rst),
    .ctl     (rank_ctl),
    .rd_data (ram_rdata),
    .sum     (sum)
  );

  mtm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIV),
    .dividend (sum),
    .done     (div_done),
    .quot     (div_quot)
  );

endmodule

/* design/mtm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_checker
// Port-level checks of the trimmed mean block, bound to its top level.
// ----------------------------------------------------------------------------
`include "multichannel_trimmed_mean_defines.svh"

module mtm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] mean_ch0,
  input logic [7:0] mean_ch1,
  input logic [7:0] mean_ch2,
  input logic [7:0] mean_ch3,
  input logic [7:0] mean_ch4,
  input logic [7:0] mean_ch5,
  input logic [7:0] mean_ch6
);

  logic [55:0] means;

  assign means = {mean_ch6, mean_ch5, mean_ch4, mean_ch3, mean_ch2, mean_ch1, mean_ch0};

  // Reset leaves the block empty and ready for a word
  `MTM_ASSERT_RST(a_reset_idle, rst, !out_valid && in_ready)

  // An accepted word keeps the block busy while it is stored
  `MTM_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

  // A new mean word shows up only as the block returns to idle
  `MTM_ASSERT_NEXT(a_load_to_idle, !out_valid || out_ready, !out_valid || in_ready)

  // Stalled result holds
  `MTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(means))

endmodule

bind multichannel_trimmed_mean mtm_checker u_mtm_checker (.*);
